>>> rtl/core/oet_pkg.sv
// Shared types, sizes and event codes of the overlap event tracker.
`default_nettype none

package oet_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PARTNER_W   = 8;
  localparam int KIND_W      = 3;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  localparam logic [KIND_W-1:0] EV_NONE     = 3'd0;
  localparam logic [KIND_W-1:0] EV_BEGIN    = 3'd1;
  localparam logic [KIND_W-1:0] EV_CONTINUE = 3'd2;
  localparam logic [KIND_W-1:0] EV_END      = 3'd3;
  localparam logic [KIND_W-1:0] EV_FULL     = 3'd4;
  localparam logic [KIND_W-1:0] EV_DONE     = 3'd5;

  typedef struct packed {
    logic                 operation;
    logic [PARTNER_W-1:0] partner_id;
    logic                 touching;
  } in_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]    event_kind;
    logic [PARTNER_W-1:0] event_partner;
    logic                 overlap_result;
    logic                 last_result;
  } out_rsp_t;

  typedef struct packed {
    logic load;
    logic report;
    logic sweep_step;
    logic sweep_end;
  } oet_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } oet_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/oet_ctrl.sv
// Sequencing state machine of the overlap event tracker.
`default_nettype none

module oet_ctrl import oet_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     operation,
  input  wire oet_sts_t sts,
  output oet_cmd_t      cmd,
  output logic          busy
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_SWEEP  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (operation == OP_SWEEP) ? ST_SWEEP : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.report = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SWEEP: begin
        if (sts.sweep_last) begin
          cmd.sweep_end = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/oet_dp.sv
// Partner table, sweep counters and result register of the overlap event tracker.
`default_nettype none

module oet_dp import oet_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_req_t  in_req,
  input  wire oet_cmd_t cmd,
  output oet_sts_t      sts,
  output logic          out_valid,
  output out_rsp_t      out_rsp
);

  logic [ID_BITS-1:0]     entry_r [TABLE_DEPTH];
  logic [ID_BITS-1:0]     entry_nxt [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] seen_r, seen_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       keep_r, keep_nxt;
  in_req_t                req_r, req_nxt;
  out_rsp_t               out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [ID_BITS-1:0]     pid;
  logic [TABLE_DEPTH-1:0] hit;
  logic                   found, found_seen, full;

  assign pid = req_r.partner_id[ID_BITS-1:0];

  // Parallel compare against the live part of the table
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      hit[j] = (CNT_W'(j) < count_r) && (entry_r[j] == pid);
    end
  end

  assign found      = |hit;
  assign found_seen = |(hit & seen_r);
  assign full       = (count_r == CNT_W'(TABLE_DEPTH));

  assign sts.sweep_last = (idx_r == count_r);

  always_comb begin
    entry_nxt     = entry_r;
    seen_nxt      = seen_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    keep_nxt      = keep_r;
    req_nxt       = req_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;

    if (cmd.load) begin
      req_nxt  = in_req;
      idx_nxt  = '0;
      keep_nxt = '0;
    end

    if (cmd.report) begin
      out_valid_nxt          = 1'b1;
      out_nxt.event_partner  = PARTNER_W'(pid);
      out_nxt.overlap_result = req_r.touching;
      out_nxt.last_result    = 1'b1;
      if (!req_r.touching) begin
        out_nxt.event_kind = EV_NONE;
      end else if (found_seen) begin
        out_nxt.event_kind = EV_NONE;
      end else if (found) begin
        seen_nxt           = seen_r | hit;
        out_nxt.event_kind = EV_CONTINUE;
      end else if (full) begin
        out_nxt.event_kind = EV_FULL;
      end else begin
        entry_nxt[count_r[IDX_W-1:0]] = pid;
        seen_nxt[count_r[IDX_W-1:0]]  = 1'b1;
        count_nxt                     = count_r + 1'b1;
        out_nxt.event_kind            = EV_BEGIN;
      end
    end

    if (cmd.sweep_step) begin
      if (seen_r[idx_r[IDX_W-1:0]]) begin
        // Compact the survivor towards the front and clear its mark
        entry_nxt[keep_r[IDX_W-1:0]] = entry_r[idx_r[IDX_W-1:0]];
        seen_nxt[keep_r[IDX_W-1:0]]  = 1'b0;
        keep_nxt                     = keep_r + 1'b1;
      end else begin
        out_valid_nxt          = 1'b1;
        out_nxt.event_kind     = EV_END;
        out_nxt.event_partner  = PARTNER_W'(entry_r[idx_r[IDX_W-1:0]]);
        out_nxt.overlap_result = 1'b0;
        out_nxt.last_result    = 1'b0;
      end
      idx_nxt = idx_r + 1'b1;
    end

    if (cmd.sweep_end) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (CNT_W'(j) >= keep_r) begin
          seen_nxt[j] = 1'b0;
        end
      end
      count_nxt              = keep_r;
      out_valid_nxt          = 1'b1;
      out_nxt.event_kind     = EV_DONE;
      out_nxt.event_partner  = '0;
      out_nxt.overlap_result = 1'b0;
      out_nxt.last_result    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    idx_r   <= idx_nxt;
    keep_r  <= keep_nxt;
    req_r   <= req_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

endmodule

`default_nettype wire

>>> rtl/core/overlap_event_tracker.sv
// Top level of the overlap event tracker: controller and datapath joined.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   in_req.operation selects an overlap report (one partner) or an
//   end-of-frame sweep of the partner table.
//   Results leave on out_rsp, each for exactly one cycle with out_valid high;
//   the receiver cannot push back, so every strobed result must be taken.
//   out_rsp.last_result marks the final result of a request.
// Timing:
//   A report first captures the request, then does the parallel compare
//   across the live table entries and the table update. Its single result
//   is strobed in the following cycle, which is also the first cycle a new
//   request can be taken, so a new report cannot overlap the one before it.
//   A sweep walks the live entries one per cycle and then gives frame done.
//   End events appear in table order as entries are visited.
// Reset:
//   rst_n (synchronous, active low) empties the table, clears all marks and
//   returns the controller to idle; no clearing pass is needed.
`default_nettype none

module overlap_event_tracker import oet_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire in_req_t in_req,
  output logic         out_valid,
  output out_rsp_t     out_rsp
);

  oet_cmd_t cmd;
  oet_sts_t sts;

  // Sequence each request: capture, then lookup or sweep walk
  oet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_req.operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Hold the table and drive the result register
  oet_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire
